[design/f2dt_pkg.sv]
// ============================================================================
// f2dt_pkg: shared types and constants of the float to decimal text block
// Sequencer states, ASCII codes and the control group of the decimal unit.
// ============================================================================
package f2dt_pkg;

  localparam int unsigned NumDigits = 20;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_POINT = 8'h2E;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_NUL   = 8'h00;

  // Biased exponent of 2^63, the first magnitude reported as out of range.
  localparam logic [7:0] EXP_LIMIT = 8'd190;
  localparam logic [7:0] EXP_BIAS  = 8'd127;
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ZERO  = 10'b0000000010,
    ST_SCALE = 10'b0000000100,
    ST_CONV  = 10'b0000001000,
    ST_BCD   = 10'b0000010000,
    ST_COUNT = 10'b0000100000,
    ST_SIGN  = 10'b0001000000,
    ST_DIGIT = 10'b0010000000,
    ST_POINT = 10'b0100000000,
    ST_FAULT = 10'b1000000000
  } f2dt_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } bcd_ctrl_t;

  typedef logic [NumDigits-1:0][3:0] bcd_word_t;

endpackage

[design/f2dt_if.sv]
// ============================================================================
// f2dt_if: item channels of the float to decimal text block
// Input channel carries one number and its digit count, output one character.
// ============================================================================
interface f2dt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [3:0]  fraction_digits;

  modport source (output valid, output value_bits, output fraction_digits, input ready);
  modport sink   (input valid, input value_bits, input fraction_digits, output ready);
endinterface

interface f2dt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       out_of_range;

  modport source (output valid, output character, output last, output out_of_range,
                  input ready);
  modport sink   (input valid, input character, input last, input out_of_range,
                  output ready);
endinterface

[design/f2dt_mul10.sv]
// ============================================================================
// f2dt_mul10: single-precision multiply by ten
// Round to nearest even, subnormal inputs, overflow to infinity.
// ============================================================================
module f2dt_mul10 (
  input  logic [31:0] value_i,
  output logic [31:0] value_o
);

  logic        sign;
  logic [7:0]  expo;
  logic [9:0]  exp_in;
  logic [23:0] mant_in;
  logic [27:0] prod;
  logic [2:0]  sh;
  logic [23:0] mant;
  logic        guard;
  logic        sticky;
  logic [24:0] rounded;
  logic [9:0]  exp_out;
  logic [22:0] frac_out;

  assign sign    = value_i[31];
  assign expo    = value_i[30:23];
  assign exp_in  = (expo == 8'd0) ? 10'd1 : {2'b00, expo};
  assign mant_in = {(expo != 8'd0), value_i[22:0]};
  // Ten times the significand as a shift-and-add.
  assign prod    = {1'b0, mant_in, 3'b000} + {3'b000, mant_in, 1'b0};

  always_comb begin
    priority if (prod[27]) begin
      sh = 3'd4;
    end else if (prod[26]) begin
      sh = 3'd3;
    end else if (prod[25]) begin
      sh = 3'd2;
    end else begin
      sh = 3'd1;
    end
  end

  always_comb begin
    unique case (sh)
      3'd4: begin
        mant = prod[27:4]; guard = prod[3]; sticky = |prod[2:0];
      end
      3'd3: begin
        mant = prod[26:3]; guard = prod[2]; sticky = |prod[1:0];
      end
      3'd2: begin
        mant = prod[25:2]; guard = prod[1]; sticky = prod[0];
      end
      default: begin
        mant = prod[24:1]; guard = prod[0]; sticky = 1'b0;
      end
    endcase
  end

  assign rounded = {1'b0, mant} + {24'd0, guard & (sticky | mant[0])};

  always_comb begin
    exp_out  = exp_in + {7'd0, sh} + {9'd0, rounded[24]};
    frac_out = rounded[24] ? rounded[23:1] : rounded[22:0];
    priority if (expo == 8'hFF) begin
      // Infinity and NaN pass through unchanged.
      value_o = value_i;
    end else if (prod[27:24] == 4'd0) begin
      // Small subnormal product: exact, and bit 23 lands in the exponent field.
      value_o = {sign, 7'd0, prod[23:0]};
    end else if (exp_out >= 10'd255) begin
      value_o = {sign, 8'hFF, 23'd0};
    end else begin
      value_o = {sign, exp_out[7:0], frac_out};
    end
  end

endmodule

[design/f2dt_bcd.sv]
// ============================================================================
// f2dt_bcd: binary to decimal shifter
// Converts a 64-bit magnitude into twenty decimal digits, two bits per cycle.
// ============================================================================
module f2dt_bcd (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  f2dt_pkg::bcd_ctrl_t ctrl_i,
  input  logic [63:0]         mag_i,
  output logic                done_o,
  output f2dt_pkg::bcd_word_t digits_o
);
  import f2dt_pkg::*;

  logic [63:0] bin_q, bin_d;
  bcd_word_t   bcd_q, bcd_d;
  logic [4:0]  cnt_q, cnt_d;
  bcd_word_t   adj1, adj2;
  logic [63:0] bin1;
  bcd_word_t   bcd1;

  function automatic bcd_word_t adjust(input bcd_word_t w);
    bcd_word_t r;
    r = w;
    for (int i = 0; i < NumDigits; i++) begin
      if (w[i] >= 4'd5) begin
        r[i] = w[i] + 4'd3;
      end
    end
    return r;
  endfunction

  always_comb begin
    adj1 = adjust(bcd_q);
    {bcd1, bin1} = {adj1, bin_q} << 1;
    adj2 = adjust(bcd1);
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = 5'd0;
    end else if (ctrl_i.step) begin
      {bcd_d, bin_d} = {adj2, bin1} << 1;
      cnt_d = cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o   = ctrl_i.step && (cnt_q == 5'd31);
  assign digits_o = bcd_q;

endmodule

[design/float_to_decimal_text.sv]
// An accepted item passes the multiply-by-ten loop, once per fraction digit, and the
// decimal shifter; then the block emits one character per cycle while the sink takes
// them. An out-of-range item skips the shifter and gives one character, and an exact
// zero skips the loop and the shifter. No new item is taken until the last character
// of the current one is emitted. Reset clears the sequencer and the output valid; no
// store needs a clearing pass.
// ============================================================================
// float_to_decimal_text: single-precision float to decimal ASCII text
// Scales by ten per fraction digit, truncates, converts and emits characters.
// ============================================================================
module float_to_decimal_text (
  input  logic      clk_i,
  input  logic      rst_ni,
  f2dt_in_if.sink   in_s,
  f2dt_out_if.source out_m
);
  import f2dt_pkg::*;

  f2dt_state_e state_q, state_d;

  // Working registers of the current item.
  logic [31:0] f_q, f_d;
  logic [3:0]  p_q, p_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [4:0]  pos_q, pos_d;
  logic [4:0]  dcnt_q, dcnt_d;

  // Output register: one character waiting for the sink.
  logic       ov_q, ov_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       oor_q, oor_d;

  logic       slot_free;
  logic       emit;
  logic [7:0] emit_char;
  logic       emit_last;
  logic       emit_oor;

  logic [31:0] f_mul;
  logic [7:0]  expo;
  logic        too_big;
  logic [86:0] wide;
  logic [63:0] mag;
  bcd_ctrl_t   bcd_ctrl;
  logic        bcd_done;
  bcd_word_t   digits;
  logic [4:0]  dcnt_w;
  logic [4:0]  top_w;
  logic        point_here;

  f2dt_mul10 u_mul (
    .value_i (f_q),
    .value_o (f_mul)
  );

  f2dt_bcd u_bcd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (bcd_ctrl),
    .mag_i    (mag),
    .done_o   (bcd_done),
    .digits_o (digits)
  );

  // Truncated magnitude of the scaled value. Exponents below the bias give zero;
  // 2^63 and above, infinity and NaN are reported as out of range.
  assign expo    = f_q[30:23];
  assign too_big = (expo == EXP_SPECIAL) || (expo >= EXP_LIMIT);
  assign wide    = {63'd0, 1'b1, f_q[22:0]} << (expo - EXP_BIAS);
  assign mag     = (expo < EXP_BIAS) ? 64'd0 : wide[86:23];

  // Count of significant decimal digits, zero for a zero magnitude.
  always_comb begin
    dcnt_w = 5'd0;
    for (int i = 0; i < NumDigits; i++) begin
      if (digits[i] != 4'd0) begin
        dcnt_w = 5'(i + 1);
      end
    end
  end

  // The first digit position emitted. With fewer digits than the fraction count,
  // the positions above the last digit hold zeros, which give the leading "0"
  // and the padding zeros after the point for free.
  always_comb begin
    if (dcnt_w == 5'd0) begin
      top_w = {1'b0, p_q};
    end else if ((dcnt_w - 5'd1) > {1'b0, p_q}) begin
      top_w = dcnt_w - 5'd1;
    end else begin
      top_w = {1'b0, p_q};
    end
  end

  // The point follows the digit at position p. With no fraction digits it only
  // appears when the magnitude is below one, giving the text "0.".
  assign point_here = (pos_q == {1'b0, p_q}) && ((p_q != 4'd0) || (dcnt_q == 5'd0));

  assign slot_free = !ov_q || out_m.ready;
  assign in_s.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    f_d       = f_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    dcnt_d    = dcnt_q;
    emit      = 1'b0;
    emit_char = ASCII_NUL;
    emit_last = 1'b0;
    emit_oor  = 1'b0;
    bcd_ctrl  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_s.valid) begin
          f_d   = in_s.value_bits;
          p_d   = in_s.fraction_digits;
          cnt_d = 4'd0;
          if (in_s.value_bits[30:0] == 31'd0) begin
            state_d = ST_ZERO;
          end else begin
            state_d = ST_SCALE;
          end
        end
      end
      ST_ZERO: begin
        // Zero of either sign is the single character "0".
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = ASCII_ZERO;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_SCALE: begin
        // One rounded multiply by ten per cycle through the multiply unit.
        if (cnt_q == p_q) begin
          state_d = ST_CONV;
        end else begin
          f_d   = f_mul;
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_CONV: begin
        if (too_big) begin
          state_d = ST_FAULT;
        end else begin
          bcd_ctrl.load = 1'b1;
          state_d       = ST_BCD;
        end
      end
      ST_BCD: begin
        bcd_ctrl.step = 1'b1;
        if (bcd_done) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        dcnt_d  = dcnt_w;
        pos_d   = top_w;
        state_d = f_q[31] ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = ASCII_MINUS;
          state_d   = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = ASCII_ZERO | {4'd0, digits[pos_q]};
          emit_last = (pos_q == 5'd0) && !point_here;
          if (point_here) begin
            state_d = ST_POINT;
          end else if (pos_q == 5'd0) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q - 5'd1;
          end
        end
      end
      ST_POINT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = ASCII_POINT;
          emit_last = (p_q == 4'd0);
          if (p_q == 4'd0) begin
            state_d = ST_IDLE;
          end else begin
            pos_d   = pos_q - 5'd1;
            state_d = ST_DIGIT;
          end
        end
      end
      ST_FAULT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = ASCII_NUL;
          emit_last = 1'b1;
          emit_oor  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The output register refills in the same cycle the sink takes its item.
  always_comb begin
    ov_d   = ov_q;
    char_d = char_q;
    last_d = last_q;
    oor_d  = oor_q;
    if (emit) begin
      ov_d   = 1'b1;
      char_d = emit_char;
      last_d = emit_last;
      oor_d  = emit_oor;
    end else if (out_m.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q    <= f_d;
    p_q    <= p_d;
    cnt_q  <= cnt_d;
    pos_q  <= pos_d;
    dcnt_q <= dcnt_d;
    char_q <= char_d;
    last_q <= last_d;
    oor_q  <= oor_d;
  end

  assign out_m.valid        = ov_q;
  assign out_m.character    = char_q;
  assign out_m.last         = last_q;
  assign out_m.out_of_range = oor_q;

`ifndef SYNTH
  a_zero_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready && (in_s.value_bits[30:0] == 31'd0)) |=> (state_q == ST_ZERO))
    else $error("zero input did not take the zero path");

  a_oor_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && oor_q) |-> (last_q && (char_q == ASCII_NUL)))
    else $error("out of range item is not a lone final character");

  a_scale_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCALE) |-> (cnt_q <= p_q))
    else $error("scaling ran past the fraction digit count");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (pos_q < 5'd20))
    else $error("digit position outside the decimal word");
`endif

endmodule
